// ===== hdl/lfp_pkg.sv =====
// shared constants and types of the led fade and pulse engine
package lfp_pkg;

   localparam int TIME_BITS_DEF  = 32;
   localparam int LEVEL_BITS_DEF = 8;
   localparam int DUR_BITS       = 16;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam int FADE_MS_RST    = 180;
   localparam int PERIOD_RST     = 1000;
   localparam int PERIOD_MIN     = 2;
   localparam int PULSE_HIGH_RST = 255;

   typedef enum logic [1:0] {
      REQ_TICK,
      REQ_FADE,
      REQ_SET,
      REQ_PULSE
   } req_code_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ANALOG_MODE,
      CSR_DEFAULT_FADE,
      CSR_PULSE_LOW,
      CSR_PULSE_HIGH,
      CSR_PULSE_PERIOD
   } csr_index_type;

endpackage

// ===== hdl/lfp_mod_unit.sv =====
// bit-serial remainder of the millisecond counter by the pulse period
module lfp_mod_unit #(
   parameter int TIME_BITS = lfp_pkg::TIME_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [TIME_BITS-1:0]         dividend,
   input  logic [lfp_pkg::DUR_BITS-1:0] divisor,
   output logic                         done,
   output logic [lfp_pkg::DUR_BITS-1:0] remainder
);

   localparam int DW = lfp_pkg::DUR_BITS;
   localparam int CW = $clog2(TIME_BITS);
   localparam logic [CW-1:0] LAST = CW'(TIME_BITS - 1);

   typedef enum logic {M_IDLE, M_RUN} state_type;

   state_type         state_ff;
   logic [TIME_BITS-1:0] shf_ff;
   logic [DW-1:0]     rem_ff;
   logic [DW-1:0]     div_ff;
   logic [CW-1:0]     cnt_ff;
   logic              done_ff;

   logic [DW:0]       trial;
   logic              fits;
   logic [DW-1:0]     rem_in;

   // one dividend bit shifted in per cycle
   always_comb begin
      trial  = {rem_ff, shf_ff[TIME_BITS-1]};
      fits   = trial >= {1'b0, div_ff};
      rem_in = fits ? DW'(trial - {1'b0, div_ff}) : DW'(trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            M_IDLE: begin
               if (start) begin
                  shf_ff   <= dividend;
                  div_ff   <= divisor;
                  rem_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= M_RUN;
               end
            end
            M_RUN: begin
               rem_ff <= rem_in;
               shf_ff <= shf_ff << 1;
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff == LAST) begin
                  done_ff  <= 1'b1;
                  state_ff <= M_IDLE;
               end
            end
            default: state_ff <= M_IDLE;
         endcase
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== hdl/lfp_interp.sv =====
// serial interpolation a + (b - a) * num / den, floor upward and ceiling downward
module lfp_interp #(
   parameter int LEVEL_BITS = lfp_pkg::LEVEL_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [LEVEL_BITS-1:0]        a,
   input  logic [LEVEL_BITS-1:0]        b,
   input  logic [lfp_pkg::DUR_BITS-1:0] num,
   input  logic [lfp_pkg::DUR_BITS-1:0] den,
   output logic                         done,
   output logic [LEVEL_BITS-1:0]        result
);

   localparam int DW = lfp_pkg::DUR_BITS;
   localparam int AW = LEVEL_BITS + DW;
   localparam int CW = $clog2(LEVEL_BITS);
   localparam logic [CW-1:0] LAST = CW'(LEVEL_BITS - 1);

   typedef enum logic [1:0] {I_IDLE, I_MUL, I_DIV, I_FIN} state_type;

   state_type             state_ff;
   logic [CW-1:0]         cnt_ff;
   logic [LEVEL_BITS-1:0] base_ff;
   logic                  desc_ff;
   logic [LEVEL_BITS-1:0] dig_ff;
   logic [DW-1:0]         num_ff;
   logic [AW-1:0]         den_sh_ff;
   logic [AW-1:0]         acc_ff;
   logic [LEVEL_BITS-1:0] quo_ff;
   logic                  done_ff;
   logic [LEVEL_BITS-1:0] result_ff;

   logic [AW-1:0]         acc_mul;
   logic                  fits;
   logic [AW-1:0]         acc_sub;
   logic                  round_up;

   always_comb begin
      // multiply one bit of the level span per cycle, msb first
      acc_mul  = (acc_ff << 1) + (dig_ff[LEVEL_BITS-1] ? AW'(num_ff) : '0);
      fits     = acc_ff >= den_sh_ff;
      acc_sub  = acc_ff - den_sh_ff;
      round_up = desc_ff && (acc_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= I_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            I_IDLE: begin
               if (start) begin
                  base_ff   <= a;
                  desc_ff   <= a > b;
                  dig_ff    <= (b >= a) ? b - a : a - b;
                  num_ff    <= num;
                  den_sh_ff <= AW'(den) << (LEVEL_BITS - 1);
                  acc_ff    <= '0;
                  cnt_ff    <= '0;
                  state_ff  <= I_MUL;
               end
            end
            I_MUL: begin
               acc_ff <= acc_mul;
               dig_ff <= dig_ff << 1;
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff == LAST) begin
                  cnt_ff   <= '0;
                  state_ff <= I_DIV;
               end
            end
            I_DIV: begin
               if (fits) begin
                  acc_ff <= acc_sub;
               end
               quo_ff    <= {quo_ff[LEVEL_BITS-2:0], fits};
               den_sh_ff <= den_sh_ff >> 1;
               cnt_ff    <= cnt_ff + CW'(1);
               if (cnt_ff == LAST) begin
                  state_ff <= I_FIN;
               end
            end
            I_FIN: begin
               // a leftover remainder rounds a falling ramp down, away from the start
               result_ff <= desc_ff ? base_ff - quo_ff - LEVEL_BITS'(round_up)
                                    : base_ff + quo_ff;
               done_ff   <= 1'b1;
               state_ff  <= I_IDLE;
            end
            default: state_ff <= I_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ===== hdl/led_fade_pulse_engine.sv =====
// led brightness engine: fades, on/off switching and a breathing pulse
//
// Words enter on the req_ channel (valid/stall): a tick advances time by one
// millisecond, the others start a fade, switch the led on or off, or enable
// the pulse. Every request word gives exactly one rsp_ word with the level,
// the pin state, the lit flag and whether a fade is still running.
// Registers are written on the csr_ channel (valid/ready) while idle.
// Each level interpolation runs in the shared serial interpolator, and a
// request needs none, one or two of them. The time remainder is kept
// incrementally; after a write of the pulse period the next request first
// passes through the bit-serial remainder unit. One request is processed
// at a time.
// A finished word sits in the output register: the next request is taken
// while rsp_stall holds it, and that request completes only once the
// output register is free.
// Synchronous reset clears the control state, not the request and response data,
// and loads the register defaults (analog, 180 ms fade, pulse 0 to 255 over 1000 ms).
module led_fade_pulse_engine #(
   parameter int TIME_BITS  = lfp_pkg::TIME_BITS_DEF,
   parameter int LEVEL_BITS = lfp_pkg::LEVEL_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_type,
   input  logic [LEVEL_BITS-1:0]             req_target_level,
   input  logic [lfp_pkg::DUR_BITS-1:0]      req_fade_ms,
   input  logic                              req_switch_on,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [LEVEL_BITS-1:0]             rsp_level,
   output logic                              rsp_pin_high,
   output logic                              rsp_lit,
   output logic                              rsp_fading,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lfp_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [lfp_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int DW = lfp_pkg::DUR_BITS;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;
   localparam logic [DW-1:0] PERIOD_MIN = DW'(lfp_pkg::PERIOD_MIN);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DISP, ST_MOD, ST_EVAL, ST_INTERP, ST_FIN
   } state_type;

   state_type             state_ff;
   logic [TIME_BITS-1:0]  now_ff;
   logic [DW-1:0]         mod_ff;
   logic                  mod_ok_ff;
   logic [DW-1:0]         el_ff;
   logic [DW-1:0]         dur_ff;
   logic [LEVEL_BITS-1:0] start_lvl_ff;
   logic [LEVEL_BITS-1:0] end_lvl_ff;
   logic [LEVEL_BITS-1:0] cur_lvl_ff;
   logic                  armed_ff;
   logic                  lit_ff;
   logic                  pulse_en_ff;
   logic                  pin_ff;
   logic                  analog_ff;
   logic [DW-1:0]         dflt_fade_ff;
   logic [LEVEL_BITS-1:0] plow_ff;
   logic [LEVEL_BITS-1:0] phigh_ff;
   logic [DW-1:0]         period_ff;
   lfp_pkg::req_code_type op_ff;
   logic [LEVEL_BITS-1:0] target_ff;
   logic [DW-1:0]         fade_ff;
   logic                  sw_ff;
   logic [1:0]            evals_ff;
   logic                  lit_fix_ff;
   logic                  rsp_valid_ff;
   logic [LEVEL_BITS-1:0] rsp_level_ff;
   logic                  rsp_pin_ff;
   logic                  rsp_lit_ff;
   logic                  rsp_fading_ff;

   logic                  req_fire;
   logic                  csr_fire;
   logic [DW-1:0]         p_eff;
   logic [DW-1:0]         p_half;
   logic [TIME_BITS-1:0]  now_inc;
   logic [DW-1:0]         mod_inc;
   logic [DW-1:0]         mod_tick;
   logic                  armed_v;
   logic                  in_fade;
   logic                  use_pulse;
   logic [DW-1:0]         tri_t;
   logic                  dig_on;
   logic [DW-1:0]         pul_rem;
   logic                  pul_low_side;
   logic                  pulse_change;
   logic                  sf_go;
   logic [LEVEL_BITS-1:0] sf_target;
   logic [DW-1:0]         sf_dur;
   logic [1:0]            evals_disp;
   logic                  eval_last;
   logic                  out_free;

   logic                  mod_start;
   logic                  mod_done;
   logic [DW-1:0]         mod_res;
   logic                  interp_start;
   logic [LEVEL_BITS-1:0] ia;
   logic [LEVEL_BITS-1:0] ib;
   logic [DW-1:0]         inum;
   logic [DW-1:0]         iden;
   logic                  interp_done;
   logic [LEVEL_BITS-1:0] interp_res;

   assign req_stall = state_ff != ST_IDLE;
   assign csr_ready = state_ff == ST_IDLE;
   assign req_fire  = req_valid && !req_stall;
   assign csr_fire  = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      p_eff    = (period_ff < PERIOD_MIN) ? PERIOD_MIN : period_ff;
      p_half   = p_eff >> 1;
      now_inc  = now_ff + TIME_BITS'(1);
      mod_inc  = mod_ff + DW'(1);
      mod_tick = (mod_inc == p_eff) ? '0 : mod_inc;
      // a fade whose time is used up is dropped before anything looks at it
      armed_v   = armed_ff && (el_ff < dur_ff);
      in_fade   = armed_v && (cur_lvl_ff != end_lvl_ff);
      use_pulse = pulse_en_ff && !in_fade;
      // triangle position folded at half the period
      tri_t  = (mod_ff > p_half) ? p_eff - mod_ff : mod_ff;
      dig_on = {mod_ff, 1'b0} < {1'b0, p_eff};
      pul_rem      = p_eff - mod_ff;
      pul_low_side = pul_rem < p_half;
      pulse_change = !pulse_en_ff && sw_ff;
      eval_last    = evals_ff == 2'd1;
   end

   // what the request starts once time is settled
   always_comb begin
      sf_go      = 1'b0;
      sf_target  = target_ff;
      sf_dur     = fade_ff;
      evals_disp = 2'd0;
      case (op_ff)
         lfp_pkg::REQ_TICK: begin
            evals_disp = 2'd1;
         end
         lfp_pkg::REQ_FADE: begin
            sf_go      = 1'b1;
            evals_disp = 2'd1;
         end
         lfp_pkg::REQ_SET: begin
            sf_go      = analog_ff;
            sf_target  = sw_ff ? LEVEL_MAX : '0;
            sf_dur     = dflt_fade_ff;
            evals_disp = analog_ff ? 2'd1 : 2'd0;
         end
         lfp_pkg::REQ_PULSE: begin
            // head for the nearer pulse bound first
            sf_go      = analog_ff && pulse_change;
            sf_target  = pul_low_side ? plow_ff : phigh_ff;
            sf_dur     = pul_low_side ? pul_rem : pul_rem - p_half;
            evals_disp = pulse_change ? (analog_ff ? 2'd2 : 2'd1) : 2'd0;
         end
         default: evals_disp = 2'd0;
      endcase
   end

   always_comb begin
      ia   = use_pulse ? plow_ff  : start_lvl_ff;
      ib   = use_pulse ? phigh_ff : end_lvl_ff;
      inum = use_pulse ? tri_t << 1 : el_ff;
      iden = use_pulse ? p_eff : dur_ff;
   end

   assign mod_start    = (state_ff == ST_DISP) && !mod_ok_ff;
   assign interp_start = (state_ff == ST_EVAL) && analog_ff && (use_pulse || armed_v);

   lfp_mod_unit #(
      .TIME_BITS (TIME_BITS)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (now_ff),
      .divisor   (p_eff),
      .done      (mod_done),
      .remainder (mod_res)
   );

   lfp_interp #(
      .LEVEL_BITS (LEVEL_BITS)
   ) u_interp (
      .clock  (clock),
      .reset  (reset),
      .start  (interp_start),
      .a      (ia),
      .b      (ib),
      .num    (inum),
      .den    (iden),
      .done   (interp_done),
      .result (interp_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         mod_ff       <= '0;
         mod_ok_ff    <= 1'b1;
         el_ff        <= '0;
         dur_ff       <= '0;
         start_lvl_ff <= '0;
         end_lvl_ff   <= '0;
         cur_lvl_ff   <= '0;
         armed_ff     <= 1'b0;
         lit_ff       <= 1'b0;
         pulse_en_ff  <= 1'b0;
         pin_ff       <= 1'b0;
         analog_ff    <= 1'b1;
         dflt_fade_ff <= DW'(lfp_pkg::FADE_MS_RST);
         plow_ff      <= '0;
         phigh_ff     <= LEVEL_BITS'(lfp_pkg::PULSE_HIGH_RST);
         period_ff    <= DW'(lfp_pkg::PERIOD_RST);
         evals_ff     <= 2'd0;
         lit_fix_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  op_ff     <= lfp_pkg::req_code_type'(req_type);
                  target_ff <= req_target_level;
                  fade_ff   <= req_fade_ms;
                  sw_ff     <= req_switch_on;
                  if (lfp_pkg::req_code_type'(req_type) == lfp_pkg::REQ_TICK) begin
                     now_ff <= now_inc;
                     if (armed_ff) begin
                        el_ff <= el_ff + DW'(1);
                     end
                     // counter wrap restarts the pulse phase at zero
                     if (now_inc == '0) begin
                        mod_ff    <= '0;
                        mod_ok_ff <= 1'b1;
                     end else begin
                        mod_ff <= mod_tick;
                     end
                  end
                  state_ff <= ST_DISP;
               end
               if (csr_fire) begin
                  case (lfp_pkg::csr_index_type'(csr_index))
                     lfp_pkg::CSR_ANALOG_MODE:  analog_ff    <= csr_wdata[0];
                     lfp_pkg::CSR_DEFAULT_FADE: dflt_fade_ff <= csr_wdata[DW-1:0];
                     lfp_pkg::CSR_PULSE_LOW:    plow_ff      <= csr_wdata[LEVEL_BITS-1:0];
                     lfp_pkg::CSR_PULSE_HIGH:   phigh_ff     <= csr_wdata[LEVEL_BITS-1:0];
                     lfp_pkg::CSR_PULSE_PERIOD: begin
                        period_ff <= csr_wdata[DW-1:0];
                        mod_ok_ff <= 1'b0;
                     end
                     default: ;
                  endcase
               end
            end
            ST_DISP: begin
               if (!mod_ok_ff) begin
                  state_ff <= ST_MOD;
               end else begin
                  if (sf_go) begin
                     start_lvl_ff <= cur_lvl_ff;
                     end_lvl_ff   <= sf_target;
                     el_ff        <= '0;
                     dur_ff       <= sf_dur;
                     armed_ff     <= 1'b1;
                  end
                  if (op_ff == lfp_pkg::REQ_SET) begin
                     lit_ff <= sw_ff;
                     if (!analog_ff) begin
                        pin_ff <= sw_ff;
                     end
                  end
                  if (op_ff == lfp_pkg::REQ_PULSE) begin
                     pulse_en_ff <= sw_ff;
                  end
                  evals_ff   <= evals_disp;
                  lit_fix_ff <= sf_go;
                  state_ff   <= (evals_disp != 2'd0) ? ST_EVAL : ST_FIN;
               end
            end
            ST_MOD: begin
               if (mod_done) begin
                  mod_ff    <= mod_res;
                  mod_ok_ff <= 1'b1;
                  state_ff  <= ST_DISP;
               end
            end
            ST_EVAL: begin
               armed_ff <= armed_v;
               if (analog_ff && (use_pulse || armed_v)) begin
                  state_ff <= ST_INTERP;
               end else begin
                  if (!analog_ff) begin
                     // digital pulse: pin high for the first half of the period
                     if (pulse_en_ff) begin
                        lit_ff <= dig_on;
                        pin_ff <= dig_on;
                     end
                  end else begin
                     cur_lvl_ff <= end_lvl_ff;
                  end
                  evals_ff <= evals_ff - 2'd1;
                  if (lit_fix_ff) begin
                     lit_ff     <= end_lvl_ff[LEVEL_BITS-1];
                     lit_fix_ff <= 1'b0;
                  end
                  state_ff <= eval_last ? ST_FIN : ST_EVAL;
               end
            end
            ST_INTERP: begin
               if (interp_done) begin
                  cur_lvl_ff <= interp_res;
                  evals_ff   <= evals_ff - 2'd1;
                  if (lit_fix_ff) begin
                     lit_ff     <= end_lvl_ff[LEVEL_BITS-1];
                     lit_fix_ff <= 1'b0;
                  end
                  state_ff <= eval_last ? ST_FIN : ST_EVAL;
               end
            end
            ST_FIN: begin
               if (out_free) begin
                  armed_ff      <= armed_v;
                  rsp_valid_ff  <= 1'b1;
                  rsp_level_ff  <= cur_lvl_ff;
                  rsp_pin_ff    <= analog_ff ? cur_lvl_ff[LEVEL_BITS-1] : pin_ff;
                  rsp_lit_ff    <= lit_ff;
                  rsp_fading_ff <= in_fade;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_level    = rsp_level_ff;
   assign rsp_pin_high = rsp_pin_ff;
   assign rsp_lit      = rsp_lit_ff;
   assign rsp_fading   = rsp_fading_ff;

endmodule

// ===== tb/sv/led_fade_pulse_engine_tb.sv =====
// self-checking testbench for the led fade and pulse engine
module led_fade_pulse_engine_tb;
   import lfp_pkg::*;

   localparam int TIME_BITS   = TIME_BITS_DEF;
   localparam int LEVEL_BITS  = LEVEL_BITS_DEF;
   localparam int LEVEL_MAX   = (1 << LEVEL_BITS) - 1;
   localparam int LEVEL_HALF  = 1 << (LEVEL_BITS - 1);
   // two interpolations plus the remainder pass after a period write
   localparam int DRAIN_CYCLES = 2 * (2 * LEVEL_BITS + 3) + 4 + TIME_BITS + 2 + 10;
   localparam int QUIET_LIMIT  = 4000;
   localparam int RANDOM_ITEMS = 200;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] level;
      logic                  pin_high;
      logic                  lit;
      logic                  fading;
   } led_outputs_t;

   class led_scoreboard;
      bit                  analog_mode;
      bit [15:0]           default_fade_ms;
      bit [LEVEL_BITS-1:0] pulse_low, pulse_high;
      bit [15:0]           pulse_period_ms;
      bit [TIME_BITS-1:0]  now_ms, fade_start_ms, fade_end_ms;
      bit [LEVEL_BITS-1:0] fade_from, fade_to, level;
      bit                  fade_armed, lit, pulsing, pin;
      led_outputs_t        expected_outputs[$];
      int                  errors;
      int                  requests_by_kind[4];

      function new();
         analog_mode     = 1'b1;
         default_fade_ms = FADE_MS_RST;
         pulse_low       = '0;
         pulse_high      = PULSE_HIGH_RST;
         pulse_period_ms = PERIOD_RST;
      endfunction

      function int pending();
         return expected_outputs.size();
      endfunction

      function void set_register(csr_index_type idx, bit [15:0] value);
         case (idx)
            CSR_ANALOG_MODE:  analog_mode = value[0];
            CSR_DEFAULT_FADE: default_fade_ms = value;
            CSR_PULSE_LOW:    pulse_low = value[LEVEL_BITS-1:0];
            CSR_PULSE_HIGH:   pulse_high = value[LEVEL_BITS-1:0];
            CSR_PULSE_PERIOD: pulse_period_ms = value;
            default: ;
         endcase
      endfunction

      // floor of a + (b - a) * num / den, rounding toward zero on the way down
      function bit [LEVEL_BITS-1:0] blend(bit [LEVEL_BITS-1:0] a, bit [LEVEL_BITS-1:0] b,
                                          bit [63:0] num, bit [63:0] den);
         bit [63:0] span;
         if (b >= a) begin
            span = b - a;
            return a + LEVEL_BITS'((span * num) / den);
         end
         span = a - b;
         return a - LEVEL_BITS'((span * num + den - 1) / den);
      endfunction

      function bit [63:0] pulse_cycle();
         return (pulse_period_ms < PERIOD_MIN) ? 64'(PERIOD_MIN) : 64'(pulse_period_ms);
      endfunction

      function void settle();
         bit [TIME_BITS-1:0] elapsed, span;
         elapsed = now_ms - fade_start_ms;
         span    = fade_end_ms - fade_start_ms;
         if (fade_armed && elapsed >= span)
            fade_armed = 1'b0;
      endfunction

      function void evaluate();
         bit [63:0]           p, t;
         bit [TIME_BITS-1:0]  elapsed, span;
         bit [LEVEL_BITS-1:0] lvl;
         bit                  in_fade;
         p = pulse_cycle();
         settle();
         if (!analog_mode) begin
            if (pulsing)
               switch_led(2 * (now_ms % p) < p);
            return;
         end
         lvl = fade_to;
         if (fade_armed) begin
            elapsed = now_ms - fade_start_ms;
            span    = fade_end_ms - fade_start_ms;
            lvl     = blend(fade_from, fade_to, elapsed, span);
         end
         in_fade = fade_armed && level != fade_to;
         if (pulsing && !in_fade) begin
            // triangle folded at half the period
            t = now_ms % p;
            if (t > p / 2)
               t = p - t;
            lvl = blend(pulse_low, pulse_high, 2 * t, p);
         end
         level = lvl;
      endfunction

      function void start_fade(bit [LEVEL_BITS-1:0] target, bit [63:0] dur);
         fade_from     = level;
         fade_to       = target;
         fade_start_ms = now_ms;
         fade_end_ms   = now_ms + dur;
         fade_armed    = 1'b1;
         evaluate();
         lit = (2 * fade_to >= LEVEL_MAX);
      endfunction

      function void switch_led(bit on);
         lit = on;
         if (analog_mode)
            start_fade(on ? LEVEL_BITS'(LEVEL_MAX) : '0, default_fade_ms);
         else
            pin = on;
      endfunction

      function void set_pulsing(bit on);
         bit [63:0] p, rem;
         bit        changed;
         changed = pulsing != on;
         pulsing = on;
         if (changed && on) begin
            // analog mode first heads for the nearer pulse bound
            if (analog_mode) begin
               p   = pulse_cycle();
               rem = p - (now_ms % p);
               if (rem < p / 2)
                  start_fade(pulse_low, rem);
               else
                  start_fade(pulse_high, rem - p / 2);
            end
            evaluate();
         end
      endfunction

      function void note_request(req_code_type kind, bit [LEVEL_BITS-1:0] target,
                                 bit [15:0] dur, bit sw);
         led_outputs_t word;
         requests_by_kind[int'(kind)]++;
         case (kind)
            REQ_TICK: begin
               now_ms = now_ms + 1'b1;
               evaluate();
            end
            REQ_FADE: start_fade(target, dur);
            REQ_SET:  switch_led(sw);
            default:  set_pulsing(sw);
         endcase
         settle();
         word.level    = level;
         word.pin_high = analog_mode ? (level >= LEVEL_HALF) : pin;
         word.lit      = lit;
         word.fading   = fade_armed && level != fade_to;
         expected_outputs.push_back(word);
      endfunction

      function void check_response(logic [LEVEL_BITS-1:0] level_seen, logic pin_seen,
                                   logic lit_seen, logic fading_seen);
         led_outputs_t want;
         if (expected_outputs.size() == 0) begin
            $error("output word with no request outstanding");
            errors++;
            return;
         end
         want = expected_outputs.pop_front();
         if (level_seen !== want.level) begin
            $error("level: expected %0d, got %0d", want.level, level_seen);
            errors++;
         end
         if (pin_seen !== want.pin_high) begin
            $error("pin_high: expected %0b, got %0b", want.pin_high, pin_seen);
            errors++;
         end
         if (lit_seen !== want.lit) begin
            $error("lit: expected %0b, got %0b", want.lit, lit_seen);
            errors++;
         end
         if (fading_seen !== want.fading) begin
            $error("fading: expected %0b, got %0b", want.fading, fading_seen);
            errors++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_type = REQ_TICK;
   logic [LEVEL_BITS-1:0]    req_target_level = '0;
   logic [DUR_BITS-1:0]      req_fade_ms = '0;
   logic                     req_switch_on = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [LEVEL_BITS-1:0]    rsp_level;
   logic                     rsp_pin_high;
   logic                     rsp_lit;
   logic                     rsp_fading;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = CSR_ANALOG_MODE;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   led_scoreboard board;
   bit            steady = 1'b0;
   int            settings_applied = 0;
   int            quiet_cycles = 0;

   led_fade_pulse_engine #(
      .TIME_BITS  (TIME_BITS),
      .LEVEL_BITS (LEVEL_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_target_level (req_target_level),
      .req_fade_ms      (req_fade_ms),
      .req_switch_on    (req_switch_on),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_level        (rsp_level),
      .rsp_pin_high     (rsp_pin_high),
      .rsp_lit          (rsp_lit),
      .rsp_fading       (rsp_fading),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 32);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_level, rsp_pin_high, rsp_lit, rsp_fading);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= QUIET_LIMIT) begin
         $error("no handshake for %0d cycles", quiet_cycles);
         $display("== FAIL ==");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task send_request(req_code_type kind, bit [LEVEL_BITS-1:0] target, bit [15:0] dur, bit sw);
      while (!steady && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_target_level <= target;
      req_fade_ms      <= dur;
      req_switch_on    <= sw;
      do @(posedge clock); while (req_stall);
      board.note_request(kind, target, dur, sw);
      @(negedge clock);
   endtask

   task hold_until_drained(int extra_cycles);
      req_valid <= 1'b0;
      do @(negedge clock); while (board.pending() != 0);
      repeat (extra_cycles) @(negedge clock);
   endtask

   task write_register(csr_index_type idx, bit [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_register(idx, value);
      @(negedge clock);
   endtask

   task apply_settings(bit mode, bit [15:0] fade, bit [LEVEL_BITS-1:0] lo,
                       bit [LEVEL_BITS-1:0] hi, bit [15:0] cycle_ms);
      hold_until_drained(DRAIN_CYCLES);
      write_register(CSR_ANALOG_MODE, mode);
      write_register(CSR_DEFAULT_FADE, fade);
      write_register(CSR_PULSE_LOW, lo);
      write_register(CSR_PULSE_HIGH, hi);
      write_register(CSR_PULSE_PERIOD, cycle_ms);
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   task run_random(int count);
      int                    roll;
      req_code_type          kind;
      bit [LEVEL_BITS-1:0]   target;
      bit [15:0]             dur;
      for (int i = 0; i < count; i++) begin
         // now and then the sender waits for every outstanding word
         if (i == count / 2 || $urandom_range(199) == 0)
            hold_until_drained(0);
         roll = $urandom_range(99);
         kind = (roll < 60) ? REQ_TICK : (roll < 75) ? REQ_FADE :
                (roll < 88) ? REQ_SET : REQ_PULSE;
         case ($urandom_range(7))
            0:       target = '0;
            1:       target = LEVEL_BITS'(LEVEL_MAX);
            default: target = $urandom;
         endcase
         case ($urandom_range(3))
            0:       dur = $urandom;
            1:       dur = $urandom_range(3);
            default: dur = $urandom_range(60);
         endcase
         send_request(kind, target, dur, $urandom);
      end
   endtask

   initial begin
      board = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register defaults straight after reset
      send_request(REQ_TICK, '0, '0, 1'b0);
      send_request(REQ_FADE, 8'hFF, 16'd0, 1'b0);      // zero duration lands at once
      send_request(REQ_FADE, 8'h00, 16'hFFFF, 1'b1);   // longest fade
      send_request(REQ_TICK, 8'hFF, 16'hFFFF, 1'b1);
      send_request(REQ_FADE, 8'd128, 16'd3, 1'b0);     // around the pin threshold
      repeat (3) send_request(REQ_TICK, '0, '0, 1'b0);
      send_request(REQ_FADE, 8'd127, 16'd2, 1'b0);
      repeat (2) send_request(REQ_TICK, '0, '0, 1'b0);
      send_request(REQ_SET, '0, '0, 1'b1);
      send_request(REQ_TICK, '0, '0, 1'b0);
      send_request(REQ_SET, '0, '0, 1'b0);
      send_request(REQ_PULSE, '0, '0, 1'b1);
      send_request(REQ_TICK, '0, '0, 1'b0);
      send_request(REQ_PULSE, '0, '0, 1'b1);           // unchanged enable
      send_request(REQ_TICK, '0, '0, 1'b0);
      send_request(REQ_PULSE, '0, '0, 1'b0);
      send_request(REQ_PULSE, '0, '0, 1'b0);
      run_random(RANDOM_ITEMS);

      apply_settings(1'b1, 16'd0, 8'd0, 8'd255, 16'd2);
      run_random(RANDOM_ITEMS);
      apply_settings(1'b1, 16'hFFFF, 8'd255, 8'd0, 16'hFFFF);    // downward triangle
      run_random(RANDOM_ITEMS);
      apply_settings(1'b0, 16'd180, 8'd0, 8'd255, 16'd20);       // pin only
      run_random(RANDOM_ITEMS);
      apply_settings(1'b1, 16'd25, 8'd200, 8'd40, 16'd1);        // period below the minimum
      steady = 1'b1;
      run_random(RANDOM_ITEMS);
      steady = 1'b0;
      apply_settings(1'b0, 16'hFFFF, 8'd255, 8'd255, 16'hFFFF);
      run_random(RANDOM_ITEMS);
      apply_settings(1'b1, 16'd40, 8'd10, 8'd240, 16'd60);
      run_random(RANDOM_ITEMS);
      repeat (2) begin
         apply_settings($urandom_range(1), $urandom_range(300), $urandom, $urandom,
                        $urandom_range(2, 500));
         run_random(RANDOM_ITEMS);
      end

      hold_until_drained(DRAIN_CYCLES);
      $display("covered %0d ticks, %0d fades, %0d on/off and %0d pulse requests",
               board.requests_by_kind[REQ_TICK], board.requests_by_kind[REQ_FADE],
               board.requests_by_kind[REQ_SET], board.requests_by_kind[REQ_PULSE]);
      $display("over %0d register settings: both modes, inverted bounds, period extremes",
               settings_applied + 1);
      if (board.errors == 0 && board.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== led_fade_pulse_engine.f =====
hdl/lfp_pkg.sv
hdl/lfp_mod_unit.sv
hdl/lfp_interp.sv
hdl/led_fade_pulse_engine.sv
tb/sv/led_fade_pulse_engine_tb.sv
